FILE: design/chp_pkg.sv
// shared constants, types and helper functions of the chroma histogram posterior unit
package chp_pkg;

    localparam int MAX_CB_BINS = 32;
    localparam int MAX_CR_BINS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int HIST_DEPTH  = MAX_CB_BINS * MAX_CR_BINS;
    localparam int ADDR_W      = $clog2(HIST_DEPTH);
    localparam int BINS_W      = 6;
    localparam int BIN_W       = 5;
    localparam int POST_W      = 17;
    localparam int DIV_STEPS   = 17;
    localparam int DCNT_W      = 5;

    localparam logic [0:0] REG_CB_BINS = 1'd0;
    localparam logic [0:0] REG_CR_BINS = 1'd1;

    localparam logic [POST_W-1:0] POST_HALF = 17'd32768;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_CONV  = 12'b0000_0000_0100,
        ST_NUM   = 12'b0000_0000_1000,
        ST_QUO   = 12'b0000_0001_0000,
        ST_FIX   = 12'b0000_0010_0000,
        ST_IDX   = 12'b0000_0100_0000,
        ST_READ  = 12'b0000_1000_0000,
        ST_UPD   = 12'b0001_0000_0000,
        ST_SUM   = 12'b0010_0000_0000,
        ST_DIV   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } chp_state_t;

    typedef struct packed {
        logic load_in;
        logic conv;
        logic num;
        logic quo;
        logic fix;
        logic idx;
        logic train_wr;
        logic mul;
        logic sum;
        logic div_step;
        logic clear_wr;
        logic out_load;
    } chp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic query;
        logic div_last;
    } chp_stat_t;

    function automatic logic [BINS_W-1:0] eff_bins(input logic [BINS_W-1:0] v,
                                                   input logic [BINS_W-1:0] maxv);
        if (v == '0) begin
            return BINS_W'(1);
        end else if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        if (v == '1) begin
            return v;
        end
        return v + COUNT_BITS'(1);
    endfunction

endpackage

FILE: design/chp_ctrl.sv
// controller state machine sequencing training, queries and the clearing pass
module chp_ctrl
    import chp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  chp_stat_t stat,
    output chp_cmd_t  cmd
);

    chp_state_t state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv   = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.num    = 1'b1;
                state_next = ST_QUO;
            end
            ST_QUO: begin
                cmd.quo    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_IDX;
            end
            ST_IDX: begin
                cmd.idx    = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (stat.query) begin
                    cmd.mul    = 1'b1;
                    state_next = ST_SUM;
                end else begin
                    cmd.train_wr = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

FILE: design/chp_dp.sv
// datapath: chroma conversion, binning, histogram memories, totals and posterior divider
module chp_dp
    import chp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  chp_cmd_t              cmd,
    output chp_stat_t             stat,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [BINS_W-1:0]     cfg_data,
    input  logic                  in_mode,
    input  logic                  in_object,
    input  logic [7:0]            in_red,
    input  logic [7:0]            in_green,
    input  logic [7:0]            in_blue,
    output logic [POST_W-1:0]     posterior,
    output logic [ADDR_W-1:0]     bin_index,
    output logic                  model_ready
);

    logic [BINS_W-1:0]     cb_bins_reg, cr_bins_reg;
    logic                  mode_reg, obj_reg;
    logic [7:0]            red_reg, green_reg, blue_reg;
    logic [15:0]           cb8_reg, cr8_reg;
    logic [22:0]           cb_num_reg, cr_num_reg;
    logic [5:0]            cb_q0_reg, cr_q0_reg;
    logic [BIN_W-1:0]      cb_bin_reg, cr_bin_reg;
    logic [ADDR_W-1:0]     idx_reg, clr_cnt_reg;
    logic [COUNT_BITS-1:0] rd_obj_reg, rd_bg_reg, obj_total_reg, bg_total_reg;
    logic [63:0]           pa_reg, pb_reg;
    logic [64:0]           d_reg;
    logic [65:0]           rem_reg;
    logic [POST_W-1:0]     q_reg, posterior_reg;
    logic [DCNT_W-1:0]     cnt_reg;
    logic                  ready_reg, mready_reg;
    logic [ADDR_W-1:0]     bin_out_reg;

    logic [COUNT_BITS-1:0] obj_mem [HIST_DEPTH];
    logic [COUNT_BITS-1:0] bg_mem  [HIST_DEPTH];

    logic [BINS_W-1:0] nb, nr;
    logic [24:0]       cb16, cr16;
    logic [36:0]       cb_prod, cr_prod;
    logic [23:0]       cb_rem, cr_rem;
    logic [5:0]        cb_qf, cr_qf;
    logic [10:0]       idx_full;
    logic              ge;
    logic [65:0]       rem_sub;

    assign nb = eff_bins(cb_bins_reg, BINS_W'(MAX_CB_BINS));
    assign nr = eff_bins(cr_bins_reg, BINS_W'(MAX_CR_BINS));

    assign cb16 = 25'd8388608 + 25'(blue_reg) * 25'd32768
                - 25'(red_reg) * 25'd11058 - 25'(green_reg) * 25'd21710;
    assign cr16 = 25'd8388608 + 25'(red_reg) * 25'd32768
                - 25'(green_reg) * 25'd27439 - 25'(blue_reg) * 25'd5329;

    assign cb_prod = 37'(cb_num_reg) * 37'd16448;
    assign cr_prod = 37'(cr_num_reg) * 37'd16448;

    assign cb_rem = 24'(cb_num_reg) - 24'(cb_q0_reg) * 24'd130560;
    assign cr_rem = 24'(cr_num_reg) - 24'(cr_q0_reg) * 24'd130560;
    assign cb_qf  = (cb_rem >= 24'd130560) ? cb_q0_reg + 6'd1 : cb_q0_reg;
    assign cr_qf  = (cr_rem >= 24'd130560) ? cr_q0_reg + 6'd1 : cr_q0_reg;

    assign idx_full = 11'(cr_bin_reg) * 11'(nb) + 11'(cb_bin_reg);

    assign ge      = (rem_reg >= 66'(d_reg));
    assign rem_sub = ge ? rem_reg - 66'(d_reg) : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb_bins_reg   <= BINS_W'(MAX_CB_BINS);
            cr_bins_reg   <= BINS_W'(MAX_CR_BINS);
            obj_total_reg <= '0;
            bg_total_reg  <= '0;
            clr_cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CB_BINS: cb_bins_reg <= cfg_data;
                    REG_CR_BINS: cr_bins_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.train_wr) begin
                if (obj_reg) begin
                    obj_total_reg <= sat_inc(obj_total_reg);
                end else begin
                    bg_total_reg <= sat_inc(bg_total_reg);
                end
            end
        end
    end

    // histogram memories
    always_ff @(posedge aclk) begin
        rd_obj_reg <= obj_mem[idx_reg];
        rd_bg_reg  <= bg_mem[idx_reg];
        if (cmd.clear_wr) begin
            obj_mem[clr_cnt_reg] <= '0;
            bg_mem[clr_cnt_reg]  <= '0;
        end else if (cmd.train_wr) begin
            if (obj_reg) begin
                obj_mem[idx_reg] <= sat_inc(rd_obj_reg);
            end else begin
                bg_mem[idx_reg] <= sat_inc(rd_bg_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg  <= in_mode;
            obj_reg   <= in_object;
            red_reg   <= in_red;
            green_reg <= in_green;
            blue_reg  <= in_blue;
        end
        if (cmd.conv) begin
            cb8_reg <= 16'((cb16 + 25'd128) >> 8);
            cr8_reg <= 16'((cr16 + 25'd128) >> 8);
        end
        if (cmd.num) begin
            cb_num_reg <= 23'(cb8_reg) * 23'(nb - BINS_W'(1)) * 23'd2 + 23'd65280;
            cr_num_reg <= 23'(cr8_reg) * 23'(nr - BINS_W'(1)) * 23'd2 + 23'd65280;
        end
        if (cmd.quo) begin
            cb_q0_reg <= cb_prod[36:31];
            cr_q0_reg <= cr_prod[36:31];
        end
        if (cmd.fix) begin
            cb_bin_reg <= (cb_qf > 6'(nb - BINS_W'(1))) ? BIN_W'(nb - BINS_W'(1))
                                                        : cb_qf[BIN_W-1:0];
            cr_bin_reg <= (cr_qf > 6'(nr - BINS_W'(1))) ? BIN_W'(nr - BINS_W'(1))
                                                        : cr_qf[BIN_W-1:0];
        end
        if (cmd.idx) begin
            idx_reg <= (idx_full > 11'(HIST_DEPTH - 1)) ? ADDR_W'(HIST_DEPTH - 1)
                                                         : idx_full[ADDR_W-1:0];
        end
        if (cmd.mul) begin
            pa_reg <= 64'(rd_obj_reg) * 64'(bg_total_reg);
            pb_reg <= 64'(rd_bg_reg) * 64'(obj_total_reg);
        end
        if (cmd.sum) begin
            d_reg     <= 65'(pa_reg) + 65'(pb_reg);
            rem_reg   <= 66'(pa_reg);
            q_reg     <= '0;
            cnt_reg   <= '0;
            ready_reg <= (obj_total_reg != '0) && (bg_total_reg != '0);
        end
        if (cmd.div_step) begin
            rem_reg <= {rem_sub[64:0], 1'b0};
            q_reg   <= {q_reg[POST_W-2:0], ge};
            cnt_reg <= cnt_reg + DCNT_W'(1);
        end
        if (cmd.out_load) begin
            posterior_reg <= (!ready_reg || d_reg == '0) ? POST_HALF : q_reg;
            bin_out_reg   <= idx_reg;
            mready_reg    <= ready_reg;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(HIST_DEPTH - 1));
    assign stat.query      = mode_reg;
    assign stat.div_last   = (cnt_reg == DCNT_W'(DIV_STEPS - 1));

    assign posterior   = posterior_reg;
    assign bin_index   = bin_out_reg;
    assign model_ready = mready_reg;

endmodule

FILE: design/chroma_histogram_posterior_unit.sv
// top level of the chroma histogram posterior unit
// Two-class colour histogram classifier on the Cb/Cr plane. After reset the block sweeps both
// 1024-entry histogram memories to zero, one entry per cycle, so s_tready stays low until the
// sweep is done. A training beat (s_tuser[0] = 0) runs the binning sequence and the
// read-modify-write of the histogram memory before the next beat is accepted. A query beat
// (s_tuser[0] = 1) also runs the radix-2 divider forming the Q1.16 posterior, and it waits
// while an earlier result still sits in the output register; that register also lets a new
// beat be taken while its result waits.
module chroma_histogram_posterior_unit
    import chp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // red, green, blue
    input  logic [1:0]        s_tuser,   // mode, in_object
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // posterior, bin_index, zero pad
    output logic [0:0]        m_tuser,   // model_ready
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [BINS_W-1:0] cfg_data
);

    chp_cmd_t          cmd;
    chp_stat_t         stat;
    logic [POST_W-1:0] posterior;
    logic [ADDR_W-1:0] bin_index;
    logic              model_ready;

    chp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chp_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_mode     (s_tuser[0]),
        .in_object   (s_tuser[1]),
        .in_red      (s_tdata[7:0]),
        .in_green    (s_tdata[15:8]),
        .in_blue     (s_tdata[23:16]),
        .posterior   (posterior),
        .bin_index   (bin_index),
        .model_ready (model_ready)
    );

    assign m_tdata = {5'd0, bin_index, posterior};
    assign m_tuser = model_ready;

endmodule
